// ===== rtl/cwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants of the congestion window control block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwc_pkg;

  // default width of the window and threshold state
  localparam int WINDOW_BITS_DEFAULT = 32;

  // width of the byte count field and of the configuration registers
  localparam int BYTE_BITS = 32;

  // segment size used in congestion avoidance
  localparam int MSS_BITS = 11;
  localparam logic [MSS_BITS-1:0] MSS_BYTES = 11'd1460;

  // width of bytes * segment size, the dividend of the avoidance step
  localparam int DIVIDEND_BITS = BYTE_BITS + MSS_BITS;

  // register reset values
  localparam logic [BYTE_BITS-1:0] INITIAL_WINDOW_RESET = 32'd14720;
  localparam logic [BYTE_BITS-1:0] MIN_WINDOW_RESET     = 32'd2920;

  // configuration register indexes
  localparam logic CFG_INITIAL_WINDOW = 1'b0;
  localparam logic CFG_MIN_WINDOW     = 1'b1;

  // event kinds
  typedef enum logic [1:0] {
    OP_ACK   = 2'd0,
    OP_LOSS  = 2'd1,
    OP_SEED  = 2'd2,
    OP_RESET = 2'd3
  } opcode_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture the input beat
    logic mul;        // register bytes * segment size
    logic div_start;  // launch the serial divider
    logic apply;      // update window, threshold and flag
    logic put;        // load the output register
  } cwc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_ca;      // acknowledgement outside slow start
    logic div_done;   // quotient ready
  } cwc_status_t;

endpackage

`default_nettype wire

// ===== rtl/cwc_divider.sv =====
// ----------------------------------------------------------------------------
// cwc_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_divider #(
  parameter int WINDOW_BITS = cwc_pkg::WINDOW_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [cwc_pkg::DIVIDEND_BITS-1:0] dividend,
  input  wire logic [WINDOW_BITS-1:0]           divisor,
  output logic      [cwc_pkg::DIVIDEND_BITS-1:0] quotient,
  output logic                                  done
);

  localparam int DB       = cwc_pkg::DIVIDEND_BITS;
  localparam int CNT_BITS = $clog2(DB + 1);

  logic [CNT_BITS-1:0]    count;
  logic [WINDOW_BITS-1:0] rem;
  logic [WINDOW_BITS-1:0] dvs;
  logic [DB-1:0]          quot;

  logic [WINDOW_BITS:0]   rem_sh;
  logic [WINDOW_BITS:0]   diff;
  logic                   ge;

  // one trial subtraction
  always_comb begin
    rem_sh = {rem, quot[DB-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = (rem_sh >= {1'b0, dvs});
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_BITS'(DB);
      end else if (count != '0) begin
        count <= count - CNT_BITS'(1);
        done  <= (count == CNT_BITS'(1));
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (count != '0) begin
      rem  <= ge ? diff[WINDOW_BITS-1:0] : rem_sh[WINDOW_BITS-1:0];
      quot <= {quot[DB-2:0], ge};
    end
  end

  assign quotient = quot;

endmodule

`default_nettype wire

// ===== rtl/cwc_datapath.sv =====
// ----------------------------------------------------------------------------
// cwc_datapath
// Window state, configuration registers, update arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_datapath #(
  parameter int WINDOW_BITS = cwc_pkg::WINDOW_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cwc_pkg::cwc_cmd_t             cmd,
  output cwc_pkg::cwc_status_t               status,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [cwc_pkg::BYTE_BITS-1:0] in_byte_count,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [cwc_pkg::BYTE_BITS-1:0] cfg_data,
  output logic      [cwc_pkg::BYTE_BITS-1:0] out_window,
  output logic      [cwc_pkg::BYTE_BITS-1:0] out_threshold,
  output logic                               out_slow_start
);

  localparam int DB       = cwc_pkg::DIVIDEND_BITS;
  localparam int ADD_BITS = ((WINDOW_BITS > DB) ? WINDOW_BITS : DB) + 1;
  localparam logic [WINDOW_BITS-1:0] WIN_MASK = '1;

  // saturate a wide value to the window width
  function automatic logic [WINDOW_BITS-1:0] sat_w(input logic [ADD_BITS-1:0] v);
    logic [WINDOW_BITS-1:0] r;
    r = (|v[ADD_BITS-1:WINDOW_BITS]) ? WIN_MASK : v[WINDOW_BITS-1:0];
    return r;
  endfunction

  logic [cwc_pkg::BYTE_BITS-1:0] initial_window;
  logic [cwc_pkg::BYTE_BITS-1:0] min_window;

  logic [WINDOW_BITS-1:0] window_bytes;
  logic [WINDOW_BITS-1:0] ss_threshold;
  logic                   in_slow_start;

  cwc_pkg::opcode_t              op;
  logic [cwc_pkg::BYTE_BITS-1:0] bytes;
  logic [DB-1:0]                 product;
  logic [DB-1:0]                 quotient;
  logic                          div_done;

  logic [ADD_BITS-1:0]    sum;
  logic [WINDOW_BITS-1:0] grown;
  logic [WINDOW_BITS-1:0] half;
  logic [WINDOW_BITS-1:0] min_w;
  logic [WINDOW_BITS-1:0] seed_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_window <= cwc_pkg::INITIAL_WINDOW_RESET;
      min_window     <= cwc_pkg::MIN_WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwc_pkg::CFG_INITIAL_WINDOW: initial_window <= cfg_data;
        cwc_pkg::CFG_MIN_WINDOW:     min_window     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat capture and segment-size product
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= cwc_pkg::opcode_t'(in_opcode);
      bytes <= in_byte_count;
    end
    if (cmd.mul) begin
      product <= DB'(bytes) * DB'(cwc_pkg::MSS_BYTES);
    end
  end

  cwc_divider #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (window_bytes),
    .quotient (quotient),
    .done     (div_done)
  );

  // status back to the controller
  assign status = '{is_ca: (op == cwc_pkg::OP_ACK) && !in_slow_start, div_done: div_done};

  // shared saturating adder and the loss and seed candidates
  always_comb begin
    sum    = ADD_BITS'(window_bytes)
           + (in_slow_start ? ADD_BITS'(bytes) : ADD_BITS'(quotient));
    grown  = sat_w(sum);
    half   = window_bytes >> 1;
    min_w  = sat_w(ADD_BITS'(min_window));
    seed_w = sat_w(ADD_BITS'(bytes));
  end

  // window state update
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bytes  <= sat_w(ADD_BITS'(cwc_pkg::INITIAL_WINDOW_RESET));
      ss_threshold  <= WIN_MASK;
      in_slow_start <= 1'b1;
    end else if (cmd.apply) begin
      unique case (op)
        cwc_pkg::OP_ACK: begin
          window_bytes <= grown;
          if (in_slow_start && (grown >= ss_threshold)) begin
            in_slow_start <= 1'b0;
          end
        end
        cwc_pkg::OP_LOSS: begin
          window_bytes  <= (half < min_w) ? min_w : half;
          ss_threshold  <= (half < min_w) ? min_w : half;
          in_slow_start <= 1'b0;
        end
        cwc_pkg::OP_SEED: begin
          if (seed_w > window_bytes) begin
            window_bytes <= seed_w;
          end
        end
        cwc_pkg::OP_RESET: begin
          window_bytes  <= sat_w(ADD_BITS'(initial_window));
          ss_threshold  <= WIN_MASK;
          in_slow_start <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      out_window     <= cwc_pkg::BYTE_BITS'(window_bytes);
      out_threshold  <= cwc_pkg::BYTE_BITS'(ss_threshold);
      out_slow_start <= in_slow_start;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cwc_ctrl
// Event sequencer: accepts a beat, runs the update and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cwc_pkg::cwc_cmd_t         cmd,
  input  wire cwc_pkg::cwc_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV_START,
    S_DIVIDE,
    S_DELIVER
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:      cmd.load      = in_valid;
      S_DISPATCH: begin
        cmd.mul   = status.is_ca;
        cmd.apply = !status.is_ca;
      end
      S_DIV_START: cmd.div_start = 1'b1;
      S_DIVIDE:    cmd.apply     = status.div_done;
      S_DELIVER:   cmd.put       = out_free;
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DELIVER) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= status.is_ca ? S_DIV_START : S_DELIVER;
        end
        S_DIV_START: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (status.div_done) begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a delivered result shows up as valid next cycle
  a_put_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> out_valid)
    else $error("result loaded but not presented");

  // the result register is never overwritten while a result waits
  a_put_free: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  // the divider is only waited on after it was launched
  a_div_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> ($past(state) == S_DIV_START || $past(state) == S_DIVIDE))
    else $error("divide state entered without a divider start");

  // a divide wait holds until the quotient is ready
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE && !status.div_done) |=> (state == S_DIVIDE))
    else $error("divide left before quotient ready");

endmodule

`default_nettype wire

// ===== rtl/congestion_window_control.sv =====
// ----------------------------------------------------------------------------
// congestion_window_control
// Reno-style congestion window engine with a stream event input and output.
// ----------------------------------------------------------------------------
// Each input beat is one event (acknowledgement, loss, seed or reset) and
// produces exactly one result beat carrying the window, the threshold and the
// slow-start flag after the event. Events are handled one at a time. A loss,
// seed, reset or slow-start acknowledgement goes from acceptance through a
// dispatch state to delivery; an acknowledgement in congestion avoidance also
// waits on the serial divider, which produces one bit of the 43-bit quotient
// bytes * 1460 / window per cycle. A finished result waits in the output
// register while the next event is taken in. Configuration writes are
// always accepted; write them only while no event is in flight, and they take
// effect on the next event that reads them.
`default_nettype none

module congestion_window_control #(
  parameter int WINDOW_BITS = cwc_pkg::WINDOW_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // event input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] byte_count
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [31:0] window, [63:32] threshold,
                                           // [64] slow_start, [71:65] zero
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  cwc_pkg::cwc_cmd_t    cmd;
  cwc_pkg::cwc_status_t status;

  logic [cwc_pkg::BYTE_BITS-1:0] out_window;
  logic [cwc_pkg::BYTE_BITS-1:0] out_threshold;
  logic                          out_slow_start;

  // configuration is taken at any time
  assign cfg_ready = 1'b1;

  cwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  cwc_datapath #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_opcode      (s_axis_tuser),
    .in_byte_count  (s_axis_tdata),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_window     (out_window),
    .out_threshold  (out_threshold),
    .out_slow_start (out_slow_start)
  );

  // result beat packing
  assign m_axis_tdata = {7'd0, out_slow_start, out_threshold, out_window};

endmodule

`default_nettype wire
